FILE: rtl/irsi_pkg.sv
// irsi_pkg: types, register indexes and reset values shared by the
// rail select and indicator core and its per-transaction update logic.
// no dependencies.
package irsi_pkg;

    localparam int unsigned MV_W    = 13;
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK       = 2'd0,
        KIND_PRESS_HIGH = 2'd1,
        KIND_PRESS_LOW  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ABSENT_MV   = 3'd0,
        CFG_LOW_MIN_MV  = 3'd1,
        CFG_LOW_MAX_MV  = 3'd2,
        CFG_HIGH_MIN_MV = 3'd3,
        CFG_HIGH_MAX_MV = 3'd4,
        CFG_FULL_LEVEL  = 3'd5,
        CFG_GREEN_LEVEL = 3'd6,
        CFG_LOCK_HOLD   = 3'd7
    } t_cfg_idx;

    localparam logic [MV_W-1:0]    RST_ABSENT_MV   = 13'd150;
    localparam logic [MV_W-1:0]    RST_LOW_MIN_MV  = 13'd1700;
    localparam logic [MV_W-1:0]    RST_LOW_MAX_MV  = 13'd1900;
    localparam logic [MV_W-1:0]    RST_HIGH_MIN_MV = 13'd3200;
    localparam logic [MV_W-1:0]    RST_HIGH_MAX_MV = 13'd3400;
    localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL  = 7'd60;
    localparam logic [LEVEL_W-1:0] RST_GREEN_LEVEL = 7'd20;
    localparam logic [HOLD_W-1:0]  RST_LOCK_HOLD   = 16'd1000;

    typedef struct packed {
        logic [MV_W-1:0]    absent_mv;
        logic [MV_W-1:0]    low_min_mv;
        logic [MV_W-1:0]    low_max_mv;
        logic [MV_W-1:0]    high_min_mv;
        logic [MV_W-1:0]    high_max_mv;
        logic [LEVEL_W-1:0] full_level;
        logic [LEVEL_W-1:0] green_level;
        logic [HOLD_W-1:0]  lock_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic               low_enabled;
        logic               high_enabled;
        logic               locked;
        logic               blink_phase;
        logic [TIME_W-1:0]  hold_until_ms;
        logic [LEVEL_W-1:0] warn_level;
        logic [LEVEL_W-1:0] low_in_level;
        logic [LEVEL_W-1:0] high_in_level;
    } t_state;

    // field order matches the output tdata packing, lowest bits last here
    typedef struct packed {
        logic               target_locked;
        logic               high_rail_on;
        logic               low_rail_on;
        logic [LEVEL_W-1:0] high_out_led;
        logic [LEVEL_W-1:0] low_out_led;
        logic [LEVEL_W-1:0] high_in_led;
        logic [LEVEL_W-1:0] low_in_led;
        logic [LEVEL_W-1:0] warn_led;
    } t_result;

endpackage

FILE: rtl/irsi_step.sv
// irsi_step: next-state and result logic for one tick or button press.
// depends on irsi_pkg.
module irsi_step
    import irsi_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  t_kind             i_kind,
    input  logic [MV_W-1:0]   i_vout_mv,
    input  logic [TIME_W-1:0] i_uptime_ms,
    output t_state            o_state,
    output t_result           o_result
);

    logic [TIME_W-1:0]  deadline;
    logic [LEVEL_W-1:0] lit_level;
    logic               in_low_win;
    logic               in_high_win;

    assign deadline = i_uptime_ms + {{(TIME_W-HOLD_W){1'b0}}, i_cfg.lock_hold_ms};

    // past the hold deadline the input led is steady, otherwise it blinks
    assign lit_level = (i_uptime_ms > i_state.hold_until_ms || i_state.blink_phase)
                     ? i_cfg.green_level : '0;

    assign in_low_win  = (i_vout_mv >= i_cfg.low_min_mv) && (i_vout_mv <= i_cfg.low_max_mv);
    assign in_high_win = (i_vout_mv >= i_cfg.high_min_mv) && (i_vout_mv <= i_cfg.high_max_mv);

    always_comb begin
        o_state = i_state;
        unique case (i_kind)
            KIND_TICK: begin
                o_state.blink_phase   = !i_state.blink_phase;
                o_state.warn_level    = '0;
                o_state.low_in_level  = '0;
                o_state.high_in_level = '0;
                if (i_vout_mv < i_cfg.absent_mv) begin
                    o_state.warn_level = i_cfg.full_level;
                    o_state.locked     = 1'b0;
                end else begin
                    o_state.locked = 1'b1;
                    if (in_low_win) begin
                        o_state.low_in_level = lit_level;
                    end else if (in_high_win) begin
                        o_state.high_in_level = lit_level;
                    end else begin
                        o_state.warn_level = i_state.blink_phase ? i_cfg.full_level : '0;
                    end
                end
            end
            KIND_PRESS_HIGH: begin
                if (i_state.high_enabled) begin
                    o_state.high_enabled = 1'b0;
                end else if (i_state.locked) begin
                    o_state.hold_until_ms = deadline;
                end else begin
                    o_state.high_enabled = 1'b1;
                end
            end
            KIND_PRESS_LOW: begin
                if (i_state.low_enabled) begin
                    o_state.low_enabled = 1'b0;
                end else if (i_state.locked) begin
                    o_state.hold_until_ms = deadline;
                end else begin
                    o_state.low_enabled = 1'b1;
                end
            end
            default: begin
                // unused kind code leaves everything as it was
            end
        endcase
    end

    always_comb begin
        o_result.warn_led      = o_state.warn_level;
        o_result.low_in_led    = o_state.low_in_level;
        o_result.high_in_led   = o_state.high_in_level;
        o_result.low_out_led   = o_state.low_enabled ? i_cfg.full_level : '0;
        o_result.high_out_led  = o_state.high_enabled ? i_cfg.full_level : '0;
        o_result.low_rail_on   = o_state.low_enabled;
        o_result.high_rail_on  = o_state.high_enabled;
        o_result.target_locked = o_state.locked;
    end

endmodule

FILE: rtl/io_rail_select_and_indicator_core.sv
// io_rail_select_and_indicator_core: top level with config registers,
// input register, rail/lock state and output register.
// depends on irsi_pkg and irsi_step.
//
// usage:
//   slave stream carries ticks (measured target voltage) and button presses;
//   tuser is the kind, tdata holds voltage and uptime. every transaction
//   returns exactly one master-stream transaction with all led levels, the
//   rail enables and the lock flag.
//   config registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata
//   while no transaction is in flight; a write takes effect at the next edge.
//   the transaction lands in the input register at the accepting edge, then
//   in the result register (which drives master tvalid) once that is free or
//   read. one transaction per cycle unless the receiver stalls; the state
//   update is a single pass of compare/add logic between the registers.
//   when the receiver stalls, the result register holds; an empty input
//   register still takes one transaction, then s_axis_tready stays low until
//   m_axis_tready returns (s_axis_tready follows it in the same cycle).
//   reset clears rails, lock, blink phase, deadline and led levels, and loads
//   the default thresholds and levels.
module io_rail_select_and_indicator_core
    import irsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: vout_mv[12:0], uptime_ms[60:13], zero fill [63:61]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: warn_led[6:0], low_in_led[13:7], high_in_led[20:14],
    // low_out_led[27:21], high_out_led[34:28], low_rail_on[35],
    // high_rail_on[36], target_locked[37], zero fill [39:38]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            n_state;
    t_result           n_result;

    logic              r_in_valid;
    t_kind             r_in_kind;
    logic [MV_W-1:0]   r_in_vout;
    logic [TIME_W-1:0] r_in_now;

    logic              r_out_valid;
    t_result           r_out_result;

    logic              advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.absent_mv    <= RST_ABSENT_MV;
            r_cfg.low_min_mv   <= RST_LOW_MIN_MV;
            r_cfg.low_max_mv   <= RST_LOW_MAX_MV;
            r_cfg.high_min_mv  <= RST_HIGH_MIN_MV;
            r_cfg.high_max_mv  <= RST_HIGH_MAX_MV;
            r_cfg.full_level   <= RST_FULL_LEVEL;
            r_cfg.green_level  <= RST_GREEN_LEVEL;
            r_cfg.lock_hold_ms <= RST_LOCK_HOLD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_ABSENT_MV:   r_cfg.absent_mv    <= i_cfg_wdata[MV_W-1:0];
                CFG_LOW_MIN_MV:  r_cfg.low_min_mv   <= i_cfg_wdata[MV_W-1:0];
                CFG_LOW_MAX_MV:  r_cfg.low_max_mv   <= i_cfg_wdata[MV_W-1:0];
                CFG_HIGH_MIN_MV: r_cfg.high_min_mv  <= i_cfg_wdata[MV_W-1:0];
                CFG_HIGH_MAX_MV: r_cfg.high_max_mv  <= i_cfg_wdata[MV_W-1:0];
                CFG_FULL_LEVEL:  r_cfg.full_level   <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_GREEN_LEVEL: r_cfg.green_level  <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_LOCK_HOLD:   r_cfg.lock_hold_ms <= i_cfg_wdata[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= t_kind'(s_axis_tuser);
            r_in_vout <= s_axis_tdata[MV_W-1:0];
            r_in_now  <= s_axis_tdata[MV_W+TIME_W-1:MV_W];
        end
    end

    irsi_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_kind      (r_in_kind),
        .i_vout_mv   (r_in_vout),
        .i_uptime_ms (r_in_now),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // state commits as the transaction moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-$bits(t_result)){1'b0}}, r_out_result};

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for io_rail_select_and_indicator_core.
// an internal rail/led predictor or a literal directed-row word checks every result.
// depends on irsi_pkg and the core rtl.
`timescale 1ns / 1ps

module tb_top;
    import irsi_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [MV_W-1:0]   MV_MAX      = 13'h1FFF;
    localparam logic [TIME_W-1:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam int                N_PHASES    = 8;
    localparam int                PHASE_ITEMS = 175;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SLUGGISH} t_rx_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MV_W-1:0]   mv;
        logic [TIME_W-1:0] ms;
        logic              lit;
        t_result           want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // predictor state and its copy of the registers
    t_cfg              cfg_shadow = '{RST_ABSENT_MV, RST_LOW_MIN_MV, RST_LOW_MAX_MV,
                                      RST_HIGH_MIN_MV, RST_HIGH_MAX_MV, RST_FULL_LEVEL,
                                      RST_GREEN_LEVEL, RST_LOCK_HOLD};
    logic              rail_lo = 1'b0;
    logic              rail_hi = 1'b0;
    logic              target_seen = 1'b0;
    logic              blink = 1'b0;
    logic [TIME_W-1:0] hold_deadline = '0;
    logic [LEVEL_W-1:0] warn_lvl = '0;
    logic [LEVEL_W-1:0] lo_in_lvl = '0;
    logic [LEVEL_W-1:0] hi_in_lvl = '0;

    t_result           pending_leds [$];
    int                n_fail = 0;
    logic [TIME_W-1:0] now_ms = '0;
    t_dir_row          dir_tab [26];

    t_rx_mode          rx_mode = RX_OPEN;
    int                rx_left = 0;
    logic [2:0]        rx_count = '0;

    io_rail_select_and_indicator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result led_word(logic [LEVEL_W-1:0] warn, logic [LEVEL_W-1:0] lo_in,
                                         logic [LEVEL_W-1:0] hi_in, logic [LEVEL_W-1:0] lo_out,
                                         logic [LEVEL_W-1:0] hi_out, logic lo_on, logic hi_on,
                                         logic locked);
        t_result r;
        r.warn_led      = warn;
        r.low_in_led    = lo_in;
        r.high_in_led   = hi_in;
        r.low_out_led   = lo_out;
        r.high_out_led  = hi_out;
        r.low_rail_on   = lo_on;
        r.high_rail_on  = hi_on;
        r.target_locked = locked;
        return r;
    endfunction

    // returns the new rail enable; a refused switch-on arms the blink deadline
    function automatic logic press_rail(logic enabled, logic [TIME_W-1:0] now);
        if (enabled)
            return 1'b0;
        if (target_seen) begin
            hold_deadline = now + TIME_W'(cfg_shadow.lock_hold_ms);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_result next_indicators(logic [KIND_W-1:0] kind, logic [MV_W-1:0] mv,
                                                logic [TIME_W-1:0] now);
        logic [LEVEL_W-1:0] on_lvl;
        case (kind)
            KIND_TICK: begin
                if (mv < cfg_shadow.absent_mv) begin
                    warn_lvl    = cfg_shadow.full_level;
                    lo_in_lvl   = '0;
                    hi_in_lvl   = '0;
                    target_seen = 1'b0;
                end else begin
                    target_seen = 1'b1;
                    // blink only while the deadline has not passed
                    if (now > hold_deadline || blink)
                        on_lvl = cfg_shadow.green_level;
                    else
                        on_lvl = '0;
                    warn_lvl  = '0;
                    lo_in_lvl = '0;
                    hi_in_lvl = '0;
                    if (mv >= cfg_shadow.low_min_mv && mv <= cfg_shadow.low_max_mv)
                        lo_in_lvl = on_lvl;
                    else if (mv >= cfg_shadow.high_min_mv && mv <= cfg_shadow.high_max_mv)
                        hi_in_lvl = on_lvl;
                    else
                        warn_lvl = blink ? cfg_shadow.full_level : '0;
                end
                blink = !blink;
            end
            KIND_PRESS_HIGH: rail_hi = press_rail(rail_hi, now);
            KIND_PRESS_LOW:  rail_lo = press_rail(rail_lo, now);
            default: ;
        endcase
        return led_word(warn_lvl, lo_in_lvl, hi_in_lvl,
                        rail_lo ? cfg_shadow.full_level : '0,
                        rail_hi ? cfg_shadow.full_level : '0,
                        rail_lo, rail_hi, target_seen);
    endfunction

    function automatic void check_field(string name, logic [LEVEL_W-1:0] want,
                                        logic [LEVEL_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_leds.size() == 0) begin
                $error("result transaction with nothing pending");
                n_fail++;
            end else begin
                want = pending_leds.pop_front();
                check_field("warn_led", want.warn_led, got.warn_led);
                check_field("low_in_led", want.low_in_led, got.low_in_led);
                check_field("high_in_led", want.high_in_led, got.high_in_led);
                check_field("low_out_led", want.low_out_led, got.low_out_led);
                check_field("high_out_led", want.high_out_led, got.high_out_led);
                check_field("low_rail_on", want.low_rail_on, got.low_rail_on);
                check_field("high_rail_on", want.high_rail_on, got.high_rail_on);
                check_field("target_locked", want.target_locked, got.target_locked);
            end
        end
    end

    // receiver backpressure, switching between patterns
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(40, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_count <= rx_count + 3'd1;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom);
            RX_PERIODIC: m_axis_tready <= (rx_count > 3'd2);
            default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [MV_W-1:0] mv,
                             input logic [TIME_W-1:0] ms, input logic lit, input t_result want);
        t_result pred;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, ms, mv};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = next_indicators(kind, mv, ms);
        pending_leds.push_back(lit ? want : pred);
    endtask

    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            s_axis_tuser  <= 2'($urandom);
        end
    endtask

    task automatic drain;
        hold_off(1);
        while (pending_leds.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_ABSENT_MV:   cfg_shadow.absent_mv    = data[MV_W-1:0];
            CFG_LOW_MIN_MV:  cfg_shadow.low_min_mv   = data[MV_W-1:0];
            CFG_LOW_MAX_MV:  cfg_shadow.low_max_mv   = data[MV_W-1:0];
            CFG_HIGH_MIN_MV: cfg_shadow.high_min_mv  = data[MV_W-1:0];
            CFG_HIGH_MAX_MV: cfg_shadow.high_max_mv  = data[MV_W-1:0];
            CFG_FULL_LEVEL:  cfg_shadow.full_level   = data[LEVEL_W-1:0];
            CFG_GREEN_LEVEL: cfg_shadow.green_level  = data[LEVEL_W-1:0];
            CFG_LOCK_HOLD:   cfg_shadow.lock_hold_ms = data[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    // bits above the narrower register widths are junk and must be dropped
    task automatic write_cfg(input t_cfg c);
        write_reg(CFG_ABSENT_MV, {3'($urandom), c.absent_mv});
        write_reg(CFG_LOW_MIN_MV, {3'($urandom), c.low_min_mv});
        write_reg(CFG_LOW_MAX_MV, {3'($urandom), c.low_max_mv});
        write_reg(CFG_HIGH_MIN_MV, {3'($urandom), c.high_min_mv});
        write_reg(CFG_HIGH_MAX_MV, {3'($urandom), c.high_max_mv});
        write_reg(CFG_FULL_LEVEL, {9'($urandom), c.full_level});
        write_reg(CFG_GREEN_LEVEL, {9'($urandom), c.green_level});
        write_reg(CFG_LOCK_HOLD, c.lock_hold_ms);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // voltages clustered on the thresholds and inside the windows, plus random and extreme values
    function automatic logic [MV_W-1:0] pick_mv;
        case ($urandom_range(0, 9))
            0:       return MV_W'($urandom_range(0, cfg_shadow.absent_mv));
            1:       return cfg_shadow.absent_mv + MV_W'($urandom_range(0, 2)) - 13'd1;
            2, 3:    return MV_W'($urandom_range(cfg_shadow.low_min_mv, cfg_shadow.low_max_mv));
            4:       return ($urandom_range(0, 1) ? cfg_shadow.low_min_mv : cfg_shadow.low_max_mv)
                            + MV_W'($urandom_range(0, 2)) - 13'd1;
            5, 6:    return MV_W'($urandom_range(cfg_shadow.high_min_mv,
                                                 cfg_shadow.high_max_mv));
            7:       return ($urandom_range(0, 1) ? cfg_shadow.high_min_mv
                                                  : cfg_shadow.high_max_mv)
                            + MV_W'($urandom_range(0, 2)) - 13'd1;
            8:       return MV_W'($urandom);
            default: return $urandom_range(0, 1) ? MV_MAX : '0;
        endcase
    endfunction

    task automatic run_random(input int n);
        int               burst;
        int               r;
        logic [KIND_W-1:0] kind;
        logic [MV_W-1:0]   mv;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 39) == 0)
                    drain();
                else if ($urandom_range(0, 2) != 0)
                    hold_off($urandom_range(1, 6));
            end
            burst--;
            r = $urandom_range(0, 99);
            if (r < 3)
                kind = KIND_UNUSED;
            else if (r < 15)
                kind = KIND_PRESS_HIGH;
            else if (r < 27)
                kind = KIND_PRESS_LOW;
            else
                kind = KIND_TICK;
            mv = (kind == KIND_TICK) ? pick_mv() : MV_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 2)
                now_ms = {16'($urandom), $urandom};
            else if (r < 3)
                now_ms = TIME_MAX - TIME_W'($urandom_range(0, 3000));
            else
                now_ms = now_ms + TIME_W'($urandom_range(0, 300));
            send_item(kind, mv, now_ms, 1'b0, '0);
        end
    endtask

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_cfg c;
        dir_tab = '{
            '{KIND_PRESS_HIGH, 13'd0, 48'd0, 1'b1, led_word(0, 0, 0, 0, 60, 0, 1, 0)},
            '{KIND_UNUSED, MV_MAX, TIME_MAX, 1'b1, led_word(0, 0, 0, 0, 60, 0, 1, 0)},
            '{KIND_PRESS_HIGH, 13'd0, 48'd5, 1'b1, led_word(0, 0, 0, 0, 0, 0, 0, 0)},
            '{KIND_TICK, 13'd0, 48'd10, 1'b1, led_word(60, 0, 0, 0, 0, 0, 0, 0)},
            '{KIND_TICK, 13'd149, 48'd20, 1'b1, led_word(60, 0, 0, 0, 0, 0, 0, 0)},
            '{KIND_TICK, 13'd150, 48'd30, 1'b0, '0},
            '{KIND_TICK, 13'd1699, 48'd40, 1'b0, '0},
            '{KIND_TICK, 13'd1700, 48'd50, 1'b0, '0},
            '{KIND_TICK, 13'd1900, 48'd60, 1'b0, '0},
            '{KIND_TICK, 13'd1901, 48'd70, 1'b0, '0},
            '{KIND_TICK, 13'd3199, 48'd80, 1'b0, '0},
            '{KIND_TICK, 13'd3200, 48'd90, 1'b0, '0},
            '{KIND_TICK, 13'd3400, 48'd100, 1'b0, '0},
            '{KIND_TICK, 13'd3401, 48'd110, 1'b0, '0},
            // refused switch-on while locked, then the deadline edges
            '{KIND_PRESS_LOW, 13'd0, 48'd120, 1'b0, '0},
            '{KIND_TICK, 13'd1800, 48'd600, 1'b0, '0},
            '{KIND_TICK, 13'd1800, 48'd1120, 1'b0, '0},
            '{KIND_TICK, 13'd1800, 48'd1121, 1'b0, '0},
            '{KIND_TICK, 13'd0, 48'd1200, 1'b1, led_word(60, 0, 0, 0, 0, 0, 0, 0)},
            '{KIND_PRESS_LOW, 13'd0, 48'd1300, 1'b1, led_word(60, 0, 0, 60, 0, 1, 0, 0)},
            '{KIND_TICK, MV_MAX, 48'd1400, 1'b0, '0},
            // an enabled rail switches off even while locked
            '{KIND_PRESS_LOW, 13'd0, 48'd1500, 1'b0, '0},
            // deadline wraps past the top of the time range
            '{KIND_PRESS_HIGH, 13'd0, TIME_MAX, 1'b0, '0},
            '{KIND_TICK, 13'd3300, TIME_MAX, 1'b0, '0},
            '{KIND_TICK, 13'd3300, 48'd500, 1'b0, '0},
            '{KIND_TICK, 13'd3300, 48'd999, 1'b0, '0}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_item(dir_tab[i].kind, dir_tab[i].mv, dir_tab[i].ms,
                      dir_tab[i].lit, dir_tab[i].want);
        now_ms = 48'd2000;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            c = cfg_shadow;
            case (ph)
                0: ;
                1: c = '0;
                2: c = '{MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, 7'd127, 7'd100, 16'hFFFF};
                3: c = '{13'd100, 13'd2000, 13'd1000, 13'd4000, 13'd3000, 7'd100, 7'd1,
                         16'd500};
                default: begin
                    c.absent_mv    = MV_W'($urandom_range(0, 400));
                    c.low_min_mv   = MV_W'($urandom_range(0, 4000));
                    c.low_max_mv   = c.low_min_mv + MV_W'($urandom_range(0, 500));
                    c.high_min_mv  = MV_W'($urandom_range(2000, 7000));
                    c.high_max_mv  = c.high_min_mv + MV_W'($urandom_range(0, 800));
                    c.full_level   = LEVEL_W'($urandom_range(0, 127));
                    c.green_level  = LEVEL_W'($urandom_range(0, 127));
                    c.lock_hold_ms = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                                 : HOLD_W'($urandom_range(0, 3000));
                end
            endcase
            if (ph != 0)
                write_cfg(c);
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
